>>> src/tcpq_pkg.sv
// Package for the two-class priority queue.
// Holds the transaction structs, command and status codes, cell types and the FSM state type.
// No dependencies.
package tcpq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int MAX_GROUP        = 16;
    localparam int KEY_W            = 32;
    localparam int GROUP_W          = 5;
    localparam int REM_W            = 5;

    localparam logic [GROUP_W-1:0] GROUP_RESET = 5'd4;

    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_CALL     = 2'd2;

    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_REMOVED    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_BOARDED    = 3'd4;
    localparam logic [2:0] ST_NONE       = 3'd5;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
        logic             express;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] key_res;
        logic [REM_W-1:0] remaining;
        logic             last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT_LEFT,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [KEY_W-1:0] key;
        logic             fast;
    } t_cell_cmd;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             cls;
    } t_cell_data;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_CALL
    } t_state;

endpackage

>>> src/two_class_priority_queue.sv
// Top level of the two-class priority queue: control state machine, output register
// and the chain of tcpq_cell instances. Depends on tcpq_pkg and tcpq_cell.
//
// The queue is a row of CAPACITY cells, head in cell 0, and every cell trades its entry
// with its neighbors. A register transaction gives its result in the output register in
// the cycle after it is taken. A remove transaction rotates the whole queue once around
// through the cell chain, one step per cycle, and drops the first matching entry as it
// passes the head; a remove on an empty queue answers like a register transaction. A call
// transaction enters the call state and then removes one entry from the head per cycle
// while the output side keeps up. Input transactions are taken one at a time and
// only while the output register is empty or being read in the same cycle, so a result
// that waits also holds off the next transaction. The group size register is written
// with i_cfg_we.
module two_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [GROUP_W-1:0] i_cfg_wdata
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [OCC_W-1:0]   r_steps, n_steps;
    logic [GROUP_W-1:0] r_left, n_left;
    logic               r_found, n_found;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [GROUP_W-1:0] r_group;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_out_free;
    logic               w_in_acc;
    logic               w_emit;
    t_out_item          w_res;
    t_cell_cmd          w_cmd;
    logic [GROUP_W-1:0] w_group_eff;
    t_cell_data         w_cell [CAPACITY];

    localparam t_cell_data CELL_SENTINEL = '{valid: 1'b1, key: '0, cls: 1'b1};
    localparam t_cell_data CELL_EMPTY    = '{valid: 1'b0, key: '0, cls: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_data w_prev;
            t_cell_data w_next;
            if (gi == 0) begin : g_first
                assign w_prev = CELL_SENTINEL;
            end else begin : g_mid
                assign w_prev = w_cell[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next = CELL_EMPTY;
            end else begin : g_body
                assign w_next = w_cell[gi+1];
            end
            tcpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .i_head  (w_cell[0]),
                .o_data  (w_cell[gi])
            );
        end
    endgenerate

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_group == '0) begin
            w_group_eff = GROUP_W'(1);
        end else if (r_group > GROUP_W'(MAX_GROUP)) begin
            w_group_eff = GROUP_W'(MAX_GROUP);
        end else begin
            w_group_eff = r_group;
        end
    end

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_steps = r_steps;
        n_left  = r_left;
        n_found = r_found;
        n_key   = r_key;
        w_cmd   = '{op: OP_HOLD, key: i_in_data.key, fast: i_in_data.express};
        w_emit  = 1'b0;
        w_res   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.command)
                        CMD_REGISTER: begin
                            w_emit        = 1'b1;
                            w_res.key_res = i_in_data.key;
                            w_res.last    = 1'b1;
                            if (r_occ == OCC_W'(CAPACITY)) begin
                                w_res.status    = ST_FULL;
                                w_res.remaining = REM_W'(r_occ);
                            end else begin
                                w_cmd.op        = OP_INSERT;
                                n_occ           = r_occ + OCC_W'(1);
                                w_res.status    = ST_REGISTERED;
                                w_res.remaining = REM_W'(n_occ);
                            end
                        end
                        CMD_REMOVE: begin
                            n_key = i_in_data.key;
                            if (r_occ == '0) begin
                                w_emit        = 1'b1;
                                w_res.status  = ST_NOT_FOUND;
                                w_res.key_res = i_in_data.key;
                                w_res.last    = 1'b1;
                            end else begin
                                n_steps = r_occ;
                                n_found = 1'b0;
                                n_state = S_REMOVE;
                            end
                        end
                        CMD_CALL: begin
                            if (r_occ == '0) begin
                                w_emit       = 1'b1;
                                w_res.status = ST_NONE;
                                w_res.last   = 1'b1;
                            end else begin
                                n_left  = w_group_eff;
                                n_state = S_CALL;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                if (r_steps != '0) begin
                    n_steps = r_steps - OCC_W'(1);
                    if (!r_found && (w_cell[0].key == r_key)) begin
                        w_cmd.op = OP_SHIFT_LEFT;
                        n_found  = 1'b1;
                        n_occ    = r_occ - OCC_W'(1);
                    end else begin
                        w_cmd.op = OP_ROTATE;
                    end
                end else if (w_out_free) begin
                    w_emit          = 1'b1;
                    w_res.status    = r_found ? ST_REMOVED : ST_NOT_FOUND;
                    w_res.key_res   = r_key;
                    w_res.remaining = REM_W'(r_occ);
                    w_res.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_CALL: begin
                if (w_out_free) begin
                    w_cmd.op        = OP_SHIFT_LEFT;
                    n_occ           = r_occ - OCC_W'(1);
                    n_left          = r_left - GROUP_W'(1);
                    w_emit          = 1'b1;
                    w_res.status    = ST_BOARDED;
                    w_res.key_res   = w_cell[0].key;
                    w_res.remaining = REM_W'(n_occ);
                    w_res.last      = (n_occ == '0) || (r_left == GROUP_W'(1));
                    if (w_res.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_steps     <= '0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_group     <= GROUP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_steps <= n_steps;
            r_left  <= n_left;
            r_found <= n_found;
            if (i_cfg_we) begin
                r_group <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

>>> src/tcpq_cell.sv
// One queue cell: holds one entry and trades it with its two neighbors.
// Inserts, shifts left or rotates as the broadcast command says.
// Depends on tcpq_pkg.
module tcpq_cell
    import tcpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  t_cell_data i_prev,
    input  t_cell_data i_next,
    input  t_cell_data i_head,
    output t_cell_data o_data
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic             r_cls;
    t_cell_data       n_data;
    logic             w_self_fast;
    logic             w_prev_fast;
    logic             w_prev_reg;

    assign o_data      = '{valid: r_valid, key: r_key, cls: r_cls};
    assign w_self_fast = r_valid & r_cls;
    assign w_prev_fast = i_prev.valid & i_prev.cls;
    assign w_prev_reg  = i_prev.valid & ~i_prev.cls;

    always_comb begin
        n_data = o_data;
        case (i_cmd.op)
            OP_INSERT: begin
                if (i_cmd.fast) begin
                    if (w_prev_fast && !w_self_fast) begin
                        n_data = '{valid: 1'b1, key: i_cmd.key, cls: 1'b1};
                    end else if (w_prev_reg) begin
                        n_data = i_prev;
                    end
                end else if (!r_valid && i_prev.valid) begin
                    n_data = '{valid: 1'b1, key: i_cmd.key, cls: 1'b0};
                end
            end
            OP_SHIFT_LEFT: begin
                n_data = i_next;
            end
            OP_ROTATE: begin
                if (r_valid && !i_next.valid) begin
                    n_data = i_head;
                end else begin
                    n_data = i_next;
                end
            end
            default: begin
                n_data = o_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_data.key;
        r_cls <= n_data.cls;
    end

endmodule
